>>> rtl/coap_retransmit_timer_table_assert.svh
// Assertion macros for the retransmission timer table.
// Used by the top level only; expects clk and rst in scope.
`ifndef COAP_RETRANSMIT_TIMER_TABLE_ASSERT_SVH
`define COAP_RETRANSMIT_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CRTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define CRTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/crtt_pkg.sv
// Shared types and constants for the retransmission timer table.
// No dependencies; used by crtt_step and coap_retransmit_timer_table.
`default_nettype none

package crtt_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RETRY_W    = 3;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned TYPE_W     = 3;
  localparam int unsigned EV_W       = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SLOTS - 1);
  localparam logic [TIME_W-1:0] NONE_WAIT = '1;

  localparam logic [CFG_DATA_W-1:0] INIT_TIMEOUT_RST = CFG_DATA_W'(2000);
  localparam logic [RETRY_W-1:0]    MAX_RETRIES_RST  = RETRY_W'(3);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES     = 1'b1;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_ARM        = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_POLL       = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_CANCEL     = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_PARK       = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_CONNECT    = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_DISCONNECT = 3'd5;

  // event codes
  localparam logic [EV_W-1:0] EV_SEND     = 3'd0;
  localparam logic [EV_W-1:0] EV_RESEND   = 3'd1;
  localparam logic [EV_W-1:0] EV_TIMEOUT  = 3'd2;
  localparam logic [EV_W-1:0] EV_SHUTDOWN = 3'd3;
  localparam logic [EV_W-1:0] EV_ARMED    = 3'd4;
  localparam logic [EV_W-1:0] EV_REFUSED  = 3'd5;
  localparam logic [EV_W-1:0] EV_DONE     = 3'd6;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
  } in_word_t;

  typedef struct packed {
    logic [EV_W-1:0]    event_res;
    logic [SLOT_W-1:0]  slot_out;
    logic [RETRY_W-1:0] retries_left;
    logic [TIME_W-1:0]  wait_ms;
    logic               last;
  } out_word_t;

  typedef enum logic [1:0] {
    STEP_WAIT,
    STEP_EXPIRE,
    STEP_ADVANCE
  } step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    logic [TIME_W-1:0]  d;
    logic [TIME_W-1:0]  st;
    logic [TIME_W-1:0]  to;
    logic [RETRY_W-1:0] r;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT_ONE,
    ST_POLL_LOAD,
    ST_POLL_STEP,
    ST_POLL_EMIT,
    ST_POLL_DONE,
    ST_DISC
  } state_t;

endpackage

`default_nettype wire

>>> rtl/crtt_step.sv
// One backoff catch-up step for a single slot: deadline test and update.
// Depends on crtt_pkg.
`default_nettype none

module crtt_step (
  input  wire logic [crtt_pkg::TIME_W-1:0]  st,
  input  wire logic [crtt_pkg::TIME_W-1:0]  to,
  input  wire logic [crtt_pkg::RETRY_W-1:0] r,
  input  wire logic [crtt_pkg::TIME_W-1:0]  now,
  input  wire logic [crtt_pkg::TIME_W-1:0]  init,
  output crtt_pkg::step_t                   res
);

  logic [crtt_pkg::TIME_W-1:0] deadline;

  assign deadline = st + to;

  always_comb begin
    res.d    = deadline - now;
    res.st   = st;
    res.to   = to;
    res.r    = r;
    res.kind = crtt_pkg::STEP_ADVANCE;
    // still waiting while the wrapped difference is strictly positive
    if (res.d != '0 && !res.d[crtt_pkg::TIME_W-1]) begin
      res.kind = crtt_pkg::STEP_WAIT;
    end else if (to == '0) begin
      res.to = init;
    end else if (r == '0) begin
      res.kind = crtt_pkg::STEP_EXPIRE;
    end else begin
      res.st = deadline;
      res.to = {to[crtt_pkg::TIME_W-2:0], 1'b0};
      res.r  = r - crtt_pkg::RETRY_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/coap_retransmit_timer_table.sv
// Retransmission timer table for confirmable requests, one slot per request.
// Input channel in_valid/in_ready/in_data carries requests: arm, poll, reply
// cancel, reply park, connect, disconnect. Output channel out_valid/out_ready/
// out_data carries event words; the final word of each request has last set.
// cfg_we/cfg_index/cfg_data write the initial timeout and retry count.
// One request is handled at a time; in_ready is high only when idle.
// Cancel, park and connect give no word.
// Arm stores its armed or refused word and presents it from the emit state.
// Poll walks every slot through one shared backoff step unit: it fetches each
// slot, runs its deadline tests (at most retries + 2 per slot), emits any word
// for it, then gives the done word.
// Disconnect scans one slot per cycle, holding at an active slot while the
// output stalls, and gives one shutdown word per active slot.
// A single output register holds the pending word; while the receiver
// stalls, the sequencer holds at its current slot and nothing is lost.
// Reset (synchronous) frees every slot, brings the link down and restores
// the registers to 2000 ms and 3 retries; slot timing stores are not cleared.
`default_nettype none

module coap_retransmit_timer_table (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [crtt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [crtt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire crtt_pkg::in_word_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output crtt_pkg::out_word_t                   out_data
);

  crtt_pkg::state_t state, state_next;

  logic [crtt_pkg::CFG_DATA_W-1:0] init_timeout;
  logic [crtt_pkg::RETRY_W-1:0]    max_retries;
  logic                            link_up;
  logic [crtt_pkg::SLOTS-1:0]      slot_active;
  logic [crtt_pkg::SLOTS-1:0]      slot_parked;

  logic [crtt_pkg::TIME_W-1:0]  slot_start_ms   [crtt_pkg::SLOTS];
  logic [crtt_pkg::TIME_W-1:0]  slot_timeout_ms [crtt_pkg::SLOTS];
  logic [crtt_pkg::RETRY_W-1:0] slot_retries    [crtt_pkg::SLOTS];

  logic [crtt_pkg::IDX_W-1:0]   idx;
  logic [crtt_pkg::TIME_W-1:0]  now_r;
  logic [crtt_pkg::TIME_W-1:0]  st_w;
  logic [crtt_pkg::TIME_W-1:0]  to_w;
  logic [crtt_pkg::RETRY_W-1:0] r_w;
  logic                         sent_w;
  logic                         resend_w;
  logic [crtt_pkg::TIME_W-1:0]  best;
  crtt_pkg::out_word_t          pend;

  logic                         in_fire;
  logic                         can_emit;
  logic                         out_load;
  crtt_pkg::out_word_t          out_next;
  logic                         slot_in_range;
  logic [crtt_pkg::IDX_W-1:0]   in_idx;
  logic                         idx_last;
  logic                         cur_live;
  logic                         more_after;
  logic [crtt_pkg::SLOTS-1:0]   hi_mask;
  logic [crtt_pkg::TIME_W-1:0]  init_eff;
  crtt_pkg::step_t              step;

  assign in_fire       = in_valid && in_ready;
  assign can_emit      = !out_valid || out_ready;
  assign slot_in_range = 32'(in_data.slot) < 32'(crtt_pkg::SLOTS);
  assign in_idx        = crtt_pkg::IDX_W'(in_data.slot);
  assign idx_last      = idx == crtt_pkg::IDX_LAST;
  assign cur_live      = slot_active[idx] && !slot_parked[idx];
  // zero initial timeout runs as 1 ms
  assign init_eff      = (init_timeout == '0) ? crtt_pkg::TIME_W'(1)
                                              : crtt_pkg::TIME_W'(init_timeout);

  always_comb begin
    for (int i = 0; i < int'(crtt_pkg::SLOTS); i++) begin
      hi_mask[i] = i > int'(idx);
    end
  end
  assign more_after = |(slot_active & hi_mask);

  crtt_step u_step (
    .st   (st_w),
    .to   (to_w),
    .r    (r_w),
    .now  (now_r),
    .init (init_eff),
    .res  (step)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      crtt_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.req_type)
            crtt_pkg::REQ_ARM:        state_next = crtt_pkg::ST_EMIT_ONE;
            crtt_pkg::REQ_POLL:       state_next = crtt_pkg::ST_POLL_LOAD;
            crtt_pkg::REQ_DISCONNECT: begin
              state_next = (|slot_active) ? crtt_pkg::ST_DISC : crtt_pkg::ST_IDLE;
            end
            default:                  state_next = crtt_pkg::ST_IDLE;
          endcase
        end
      end
      crtt_pkg::ST_EMIT_ONE: begin
        if (can_emit) state_next = crtt_pkg::ST_IDLE;
      end
      crtt_pkg::ST_POLL_LOAD: begin
        if (cur_live) state_next = crtt_pkg::ST_POLL_STEP;
        else if (idx_last) state_next = crtt_pkg::ST_POLL_DONE;
      end
      crtt_pkg::ST_POLL_STEP: begin
        case (step.kind)
          crtt_pkg::STEP_WAIT: begin
            if (sent_w) state_next = crtt_pkg::ST_POLL_EMIT;
            else if (idx_last) state_next = crtt_pkg::ST_POLL_DONE;
            else state_next = crtt_pkg::ST_POLL_LOAD;
          end
          crtt_pkg::STEP_EXPIRE: state_next = crtt_pkg::ST_POLL_EMIT;
          default:               state_next = crtt_pkg::ST_POLL_STEP;
        endcase
      end
      crtt_pkg::ST_POLL_EMIT: begin
        if (can_emit) begin
          state_next = idx_last ? crtt_pkg::ST_POLL_DONE : crtt_pkg::ST_POLL_LOAD;
        end
      end
      crtt_pkg::ST_POLL_DONE: begin
        if (can_emit) state_next = crtt_pkg::ST_IDLE;
      end
      crtt_pkg::ST_DISC: begin
        if ((!slot_active[idx] || can_emit) && idx_last) state_next = crtt_pkg::ST_IDLE;
      end
      default: state_next = crtt_pkg::ST_IDLE;
    endcase
  end

  // handshake and output word selection
  always_comb begin
    in_ready = state == crtt_pkg::ST_IDLE;
    out_load = 1'b0;
    out_next = pend;
    case (state)
      crtt_pkg::ST_EMIT_ONE, crtt_pkg::ST_POLL_EMIT: begin
        out_load = can_emit;
      end
      crtt_pkg::ST_POLL_DONE: begin
        out_load = can_emit;
        out_next = '{event_res: crtt_pkg::EV_DONE, slot_out: '0, retries_left: '0,
                     wait_ms: best, last: 1'b1};
      end
      crtt_pkg::ST_DISC: begin
        out_load = slot_active[idx] && can_emit;
        out_next = '{event_res: crtt_pkg::EV_SHUTDOWN,
                     slot_out: crtt_pkg::SLOT_W'(idx), retries_left: '0,
                     wait_ms: crtt_pkg::NONE_WAIT, last: !more_after};
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= crtt_pkg::ST_IDLE;
      init_timeout <= crtt_pkg::INIT_TIMEOUT_RST;
      max_retries  <= crtt_pkg::MAX_RETRIES_RST;
      link_up      <= 1'b0;
      slot_active  <= '0;
      slot_parked  <= '0;
      out_valid    <= 1'b0;
      idx          <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          crtt_pkg::CFG_INITIAL_TIMEOUT: init_timeout <= cfg_data;
          crtt_pkg::CFG_MAX_RETRIES:     max_retries  <= cfg_data[crtt_pkg::RETRY_W-1:0];
          default: ;
        endcase
      end

      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (state)
        crtt_pkg::ST_IDLE: begin
          idx <= '0;
          if (in_fire) begin
            case (in_data.req_type)
              crtt_pkg::REQ_ARM: begin
                if (link_up && slot_in_range) begin
                  slot_active[in_idx] <= 1'b1;
                  slot_parked[in_idx] <= 1'b0;
                end
              end
              crtt_pkg::REQ_CANCEL: begin
                if (slot_in_range) begin
                  slot_active[in_idx] <= 1'b0;
                  slot_parked[in_idx] <= 1'b0;
                end
              end
              crtt_pkg::REQ_PARK: begin
                if (slot_in_range && slot_active[in_idx]) slot_parked[in_idx] <= 1'b1;
              end
              crtt_pkg::REQ_CONNECT:    link_up <= 1'b1;
              crtt_pkg::REQ_DISCONNECT: link_up <= 1'b0;
              default: ;
            endcase
          end
        end
        crtt_pkg::ST_POLL_LOAD: begin
          if (!cur_live && !idx_last) idx <= idx + crtt_pkg::IDX_W'(1);
        end
        crtt_pkg::ST_POLL_STEP: begin
          if (step.kind == crtt_pkg::STEP_EXPIRE) begin
            slot_active[idx] <= 1'b0;
            slot_parked[idx] <= 1'b0;
          end else if (step.kind == crtt_pkg::STEP_WAIT && !sent_w && !idx_last) begin
            idx <= idx + crtt_pkg::IDX_W'(1);
          end
        end
        crtt_pkg::ST_POLL_EMIT: begin
          if (can_emit && !idx_last) idx <= idx + crtt_pkg::IDX_W'(1);
        end
        crtt_pkg::ST_DISC: begin
          if (!slot_active[idx] || can_emit) begin
            slot_active[idx] <= 1'b0;
            slot_parked[idx] <= 1'b0;
            if (!idx_last) idx <= idx + crtt_pkg::IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // slot stores, working registers and output word
  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_next;

    case (state)
      crtt_pkg::ST_IDLE: begin
        now_r <= in_data.now;
        best  <= crtt_pkg::NONE_WAIT;
        if (in_fire && in_data.req_type == crtt_pkg::REQ_ARM) begin
          if (link_up && slot_in_range) begin
            slot_start_ms[in_idx]   <= in_data.now;
            slot_timeout_ms[in_idx] <= '0;
            slot_retries[in_idx]    <= max_retries;
            pend <= '{event_res: crtt_pkg::EV_ARMED, slot_out: in_data.slot,
                      retries_left: max_retries, wait_ms: crtt_pkg::NONE_WAIT,
                      last: 1'b1};
          end else begin
            pend <= '{event_res: crtt_pkg::EV_REFUSED, slot_out: in_data.slot,
                      retries_left: '0, wait_ms: crtt_pkg::NONE_WAIT, last: 1'b1};
          end
        end
      end
      crtt_pkg::ST_POLL_LOAD: begin
        st_w     <= slot_start_ms[idx];
        to_w     <= slot_timeout_ms[idx];
        r_w      <= slot_retries[idx];
        resend_w <= slot_timeout_ms[idx] != '0;
        sent_w   <= 1'b0;
      end
      crtt_pkg::ST_POLL_STEP: begin
        case (step.kind)
          crtt_pkg::STEP_WAIT: begin
            slot_start_ms[idx]   <= st_w;
            slot_timeout_ms[idx] <= to_w;
            slot_retries[idx]    <= r_w;
            if (step.d < best) best <= step.d;
            pend <= '{event_res: resend_w ? crtt_pkg::EV_RESEND : crtt_pkg::EV_SEND,
                      slot_out: crtt_pkg::SLOT_W'(idx), retries_left: r_w,
                      wait_ms: step.d, last: 1'b0};
          end
          crtt_pkg::STEP_EXPIRE: begin
            pend <= '{event_res: crtt_pkg::EV_TIMEOUT, slot_out: crtt_pkg::SLOT_W'(idx),
                      retries_left: '0, wait_ms: crtt_pkg::NONE_WAIT, last: 1'b0};
          end
          default: begin
            st_w   <= step.st;
            to_w   <= step.to;
            r_w    <= step.r;
            sent_w <= 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

`include "coap_retransmit_timer_table_assert.svh"

  `CRTT_ASSERT_NEXT(a_poll_starts_scan, in_fire && in_data.req_type == crtt_pkg::REQ_POLL, state == crtt_pkg::ST_POLL_LOAD && idx == '0, "poll did not start slot scan")
  `CRTT_ASSERT_NEXT(a_retry_taken, state == crtt_pkg::ST_POLL_STEP && step.kind == crtt_pkg::STEP_ADVANCE && to_w != '0, r_w == $past(r_w) - crtt_pkg::RETRY_W'(1) && sent_w, "backoff advance did not take one retry")
  `CRTT_ASSERT_NOW(a_done_word, out_valid && out_data.event_res == crtt_pkg::EV_DONE, out_data.last && out_data.slot_out == '0, "done word without last or with a slot")
  `CRTT_ASSERT_NEXT(a_link_down, in_fire && in_data.req_type == crtt_pkg::REQ_DISCONNECT, !link_up, "link still up after disconnect")

endmodule

`default_nettype wire
